### design/ffrma_pkg.sv
// Package for the first-fit resource map allocator.
// Request and result types, register codes, op and status codes.
// No dependencies.
`timescale 1ns / 1ps
package ffrma_pkg;

    localparam int MAP_SLOTS_DEF = 32;
    localparam int ADDR_BITS_DEF = 16;
    localparam int LIMIT_BITS    = 6;
    localparam int PADDR_BITS    = 1;

    localparam logic [PADDR_BITS-1:0] REG_MAP_LIMIT = 1'b0;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET   = 6'd32;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_EXPAND = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_LOST    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [ADDR_BITS_DEF-1:0] size;
        logic [ADDR_BITS_DEF-1:0] addr;
        logic [ADDR_BITS_DEF-1:0] new_size;
    } t_req;

    typedef struct packed {
        logic [ADDR_BITS_DEF-1:0] result_addr;
        logic [1:0]               status;
        logic                     relocated;
        logic [ADDR_BITS_DEF-1:0] lost_addr;
        logic [ADDR_BITS_DEF-1:0] lost_size;
    } t_rsp;

endpackage

### design/ffrma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module ffrma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/first_fit_resource_map_allocator.sv
// First-fit resource map allocator, top level.
// Uses ffrma_pkg and ffrma_ram (the segment table).
`timescale 1ns / 1ps
// The allocator keeps an address-sorted table of free segments in a small RAM
// and serves one request at a time. A request is taken only while the block
// is idle; it then walks the table one entry at a time, checks the entries
// with combinational adders and comparators, and shifts the tail of the table up
// or down one entry per step when a segment is inserted or removed. Each
// entry examined is read, waited on for the registered RAM data and then
// examined; opening a gap reads and writes each entry moved, and closing one
// reads, waits for and writes each entry moved.
// The result is held in an output register until it is taken; the next
// request is accepted only once the result has left. Map_limit is to be
// written through the APB port only while the block is idle; the block
// itself does not enforce this. It is used clamped to 2..MAP_SLOTS. No
// clearing pass is needed after reset: the segment count starts at zero
// and no entry beyond it is ever read.
module first_fit_resource_map_allocator #(
    parameter int MAP_SLOTS = ffrma_pkg::MAP_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  ffrma_pkg::t_req                i_req,
    output logic                           o_valid,
    input  logic                           i_stall,
    output ffrma_pkg::t_rsp                o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ffrma_pkg::PADDR_BITS+1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    localparam int IW = $clog2(MAP_SLOTS);
    localparam int CW = $clog2(MAP_SLOTS + 1);
    localparam int AW = ffrma_pkg::ADDR_BITS_DEF;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;  // issue read of r_idx
    localparam logic [3:0] S_WT    = 4'd2;  // wait for registered data
    localparam logic [3:0] S_CHK   = 4'd3;  // examine entry
    localparam logic [3:0] S_RMRD  = 4'd4;  // remove: read idx+1
    localparam logic [3:0] S_RMWT  = 4'd5;
    localparam logic [3:0] S_RMWR  = 4'd6;  // write it to idx
    localparam logic [3:0] S_INRD  = 4'd7;  // insert: read idx-1
    localparam logic [3:0] S_INWT  = 4'd8;
    localparam logic [3:0] S_INWR  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_FREE2 = 4'd11; // free: check right neighbour
    localparam logic [3:0] S_FWT   = 4'd12;
    localparam logic [3:0] S_OVRD  = 4'd13; // overflow: read next-to-last entry
    localparam logic [3:0] S_OVWT  = 4'd14;

    logic [3:0]  r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_stop, n_stop;      // index at which a shift stops
    logic [5:0]  r_limit;
    ffrma_pkg::t_req r_req, n_req;
    ffrma_pkg::t_rsp r_rsp, n_rsp;
    logic        r_ovalid, n_ovalid;
    logic        r_found, n_found;       // expand: a relocation fit is known
    logic [CW-1:0] r_fit, n_fit;
    logic        r_inplace, n_inplace;   // expand: relocation take in progress
    logic        r_lm, n_lm;
    logic [AW-1:0] r_lbase, n_lbase;     // left neighbour kept for free
    logic [AW:0]   r_llen, n_llen;
    logic        r_ovf, n_ovf;           // insertion overflows the limit

    logic            ram_we;
    logic [IW-1:0]   ram_wa, ram_ra;
    logic [2*AW-1:0] ram_wd, ram_rd;
    logic [AW-1:0]   e_base, e_len;

    ffrma_ram #(.WIDTH(2 * AW), .DEPTH(MAP_SLOTS)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );

    assign e_base = ram_rd[2*AW-1:AW];
    assign e_len  = ram_rd[AW-1:0];

    // Clamped limit, minus one: the maximum number of segments kept.
    logic [CW-1:0] max_segs;
    always_comb begin
        if (r_limit < 6'd2) begin
            max_segs = CW'(1);
        end else if (32'(r_limit) > MAP_SLOTS) begin
            max_segs = CW'(MAP_SLOTS - 1);
        end else begin
            max_segs = CW'(r_limit) - CW'(1);
        end
    end

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[ffrma_pkg::PADDR_BITS+1:2] == ffrma_pkg::REG_MAP_LIMIT)
                    ? {26'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ffrma_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[ffrma_pkg::PADDR_BITS+1:2] == ffrma_pkg::REG_MAP_LIMIT) begin
            r_limit <= pwdata[5:0];
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    // Combinational arithmetic: request end, entry end and size sum.
    logic [AW:0] sum_a;
    logic [AW:0] ent_end;
    logic [AW:0] req_end;
    assign req_end = {1'b0, r_req.addr} + {1'b0, r_req.size};
    assign ent_end = {1'b0, e_base} + {1'b0, e_len};
    assign sum_a   = {1'b0, r_req.size} + {1'b0, e_len};

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;  n_idx = r_idx;  n_stop = r_stop;
        n_req = r_req;  n_rsp = r_rsp;  n_ovalid = r_ovalid;
        n_found = r_found;  n_fit = r_fit;  n_inplace = r_inplace;
        n_lm = r_lm;  n_lbase = r_lbase;  n_llen = r_llen;  n_ovf = r_ovf;
        ram_we = 1'b0;  ram_wa = r_idx[IW-1:0];  ram_wd = ram_rd;
        ram_ra = r_idx[IW-1:0];

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    n_req = i_req;
                    n_rsp = '0;
                    n_idx = '0;
                    n_found = 1'b0;  n_fit = '0;  n_inplace = 1'b0;
                    n_lm = 1'b0;  n_ovf = 1'b0;
                    n_state = S_RD;
                    case (i_req.op)
                        ffrma_pkg::OP_ALLOC: begin
                            if (i_req.size == '0) begin
                                n_rsp.status = ffrma_pkg::ST_BAD;  n_state = S_DONE;
                            end
                        end
                        ffrma_pkg::OP_FREE: begin
                            if (i_req.size == '0 || i_req.addr == '0 ||
                                ({1'b0, i_req.addr} + {1'b0, i_req.size}) >
                                {1'b1, {AW{1'b0}}}) begin
                                n_rsp.status = ffrma_pkg::ST_BAD;  n_state = S_DONE;
                            end
                        end
                        ffrma_pkg::OP_EXPAND: begin
                            if (i_req.addr == '0 || i_req.new_size == '0 ||
                                i_req.new_size <= i_req.size) begin
                                n_rsp.status = ffrma_pkg::ST_BAD;  n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_rsp.status = ffrma_pkg::ST_BAD;  n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_RD: begin
                // End of table reached without a decision.
                if (r_idx >= r_cnt) begin
                    case (r_req.op)
                        ffrma_pkg::OP_ALLOC: begin
                            n_rsp.status = ffrma_pkg::ST_NOSPACE;  n_state = S_DONE;
                        end
                        ffrma_pkg::OP_FREE: begin
                            n_state = S_FREE2;
                        end
                        default: begin
                            if (r_found) begin
                                n_idx = r_fit;  n_inplace = 1'b0;
                                n_state = S_WT;  ram_ra = r_fit[IW-1:0];
                                n_rsp.relocated = 1'b1;
                                n_found = 1'b0;  // cleared; r_inplace with r_stop marks the take
                                n_inplace = 1'b1;
                                n_stop = '1;
                            end else begin
                                n_rsp.status = ffrma_pkg::ST_NOSPACE;  n_state = S_DONE;
                            end
                        end
                    endcase
                end else begin
                    n_state = S_WT;
                end
            end

            S_WT: begin
                n_state = S_CHK;
            end

            S_CHK: begin
                n_state = S_RD;
                n_idx = r_idx + CW'(1);
                if (r_req.op == ffrma_pkg::OP_EXPAND && r_stop == '1 && r_inplace) begin
                    // Relocation: take new_size from the fit entry.
                    n_rsp.result_addr = e_base;
                    ram_we = 1'b1;
                    ram_wd = {e_base + r_req.new_size, e_len - r_req.new_size};
                    n_idx = r_idx;
                    n_state = (e_len == r_req.new_size) ? S_RMRD : S_DONE;
                end else if (r_req.op == ffrma_pkg::OP_ALLOC) begin
                    if (e_len >= r_req.size) begin
                        n_rsp.result_addr = e_base;
                        ram_we = 1'b1;
                        ram_wd = {e_base + r_req.size, e_len - r_req.size};
                        n_idx = r_idx;
                        n_state = (e_len == r_req.size) ? S_RMRD : S_DONE;
                    end
                end else if (r_req.op == ffrma_pkg::OP_FREE) begin
                    if (e_base <= r_req.addr) begin
                        n_lm = 1'b1;  n_lbase = e_base;  n_llen = ent_end;
                    end else begin
                        n_state = S_FREE2;  n_idx = r_idx;
                    end
                end else begin
                    // Expand scan.
                    if (!r_found && e_len >= r_req.new_size) begin
                        n_found = 1'b1;  n_fit = r_idx;
                    end
                    if ({1'b0, e_base} >= req_end) begin
                        if ({1'b0, e_base} == req_end &&
                            sum_a >= {1'b0, r_req.new_size}) begin
                            n_rsp.result_addr = r_req.addr;
                            ram_we = 1'b1;
                            ram_wd = {e_base + (r_req.new_size - r_req.size),
                                      AW'(sum_a - {1'b0, r_req.new_size})};
                            n_idx = r_idx;
                            n_state = (sum_a == {1'b0, r_req.new_size}) ? S_RMRD : S_DONE;
                        end else if (!r_found && !(e_len >= r_req.new_size)) begin
                            // Continue searching for a relocation fit only.
                            n_stop = '0;
                        end else if (r_found || e_len >= r_req.new_size) begin
                            n_idx = r_cnt;
                        end
                    end
                end
            end

            // Free decision: r_lm/r_llen hold the left neighbour (entry idx-1),
            // r_idx is the first entry above addr.
            S_FREE2: begin
                if (r_lm && r_llen > {1'b0, r_req.addr}) begin
                    n_rsp.status = ffrma_pkg::ST_BAD;  n_state = S_DONE;
                end else if (r_idx < r_cnt) begin
                    ram_ra = r_idx[IW-1:0];  n_state = S_FWT;
                end else if (r_lm && r_llen == {1'b0, r_req.addr}) begin
                    ram_we = 1'b1;  ram_wa = IW'(r_idx - CW'(1));
                    ram_wd = {r_lbase, AW'(r_llen - {1'b0, r_lbase}) + r_req.size};
                    n_state = S_DONE;
                end else begin
                    n_stop = r_idx;  n_idx = r_cnt;
                    n_cnt = r_cnt + CW'(1);
                    n_ovf = (r_cnt + CW'(1)) > max_segs;
                    n_state = S_INRD;
                end
            end

            S_FWT: begin
                if (req_end > {1'b0, e_base}) begin
                    n_rsp.status = ffrma_pkg::ST_BAD;  n_state = S_DONE;
                end else if (r_lm && r_llen == {1'b0, r_req.addr}) begin
                    ram_we = 1'b1;  ram_wa = IW'(r_idx - CW'(1));
                    if (req_end == {1'b0, e_base}) begin
                        ram_wd = {r_lbase,
                                  AW'(r_llen - {1'b0, r_lbase}) + r_req.size + e_len};
                        n_state = S_RMRD;
                    end else begin
                        ram_wd = {r_lbase, AW'(r_llen - {1'b0, r_lbase}) + r_req.size};
                        n_state = S_DONE;
                    end
                end else if (req_end == {1'b0, e_base}) begin
                    ram_we = 1'b1;
                    ram_wd = {r_req.addr, e_len + r_req.size};
                    n_state = S_DONE;
                end else begin
                    n_stop = r_idx;  n_idx = r_cnt;
                    n_cnt = r_cnt + CW'(1);
                    n_ovf = (r_cnt + CW'(1)) > max_segs;
                    n_state = S_INRD;
                end
            end

            // Insertion: shift entries [stop, cnt) up by one, top first.
            S_INRD: begin
                if (r_idx == r_stop) begin
                    ram_we = 1'b1;
                    ram_wd = {r_req.addr, r_req.size};
                    if (r_ovf) begin
                        n_idx = r_cnt - CW'(1);
                        n_state = S_OVRD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    ram_ra = IW'(r_idx - CW'(1));
                    n_state = S_INWT;
                end
            end

            S_INWT: begin
                ram_we = 1'b1;
                n_idx = r_idx - CW'(1);
                n_state = S_INRD;
            end

            // Overflow: report entry cnt-2 and move the last into it.
            S_OVRD: begin
                ram_ra = IW'(r_idx - CW'(1));
                n_state = S_OVWT;
            end

            S_OVWT: begin
                n_rsp.lost_addr = e_base;  n_rsp.lost_size = e_len;
                n_rsp.status = ffrma_pkg::ST_LOST;
                ram_ra = r_idx[IW-1:0];
                n_idx = r_idx - CW'(1);
                n_cnt = r_cnt - CW'(1);
                n_state = S_INWR;
            end

            S_INWR: begin
                ram_we = 1'b1;
                n_state = S_DONE;
            end

            // Removal: shift entries (idx, cnt) down by one.
            S_RMRD: begin
                if (r_idx + CW'(1) >= r_cnt) begin
                    n_cnt = r_cnt - CW'(1);
                    n_state = S_DONE;
                end else begin
                    ram_ra = IW'(r_idx + CW'(1));
                    n_state = S_RMWT;
                end
            end

            // Keep the read address on idx+1 so the data still holds that entry.
            S_RMWT: begin
                ram_ra = IW'(r_idx + CW'(1));
                n_state = S_RMWR;
            end

            S_RMWR: begin
                ram_we = 1'b1;
                n_idx = r_idx + CW'(1);
                n_state = S_RMRD;
            end

            S_DONE: begin
                n_ovalid = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;  r_stop <= n_stop;  r_req <= n_req;  r_rsp <= n_rsp;
        r_found <= n_found;  r_fit <= n_fit;  r_inplace <= n_inplace;
        r_lm <= n_lm;  r_lbase <= n_lbase;  r_llen <= n_llen;  r_ovf <= n_ovf;
    end

    // The segment count never exceeds the table size.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAP_SLOTS))
        else $error("segment count beyond table size");

    // A result appears only after the sequencer has finished a request.
    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_DONE)
        else $error("result without completed request");

    // No request is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> o_stall)
        else $error("input open while a result is pending");

    // Lost segments are reported only with the matching status.
    a_lost_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_rsp.status != ffrma_pkg::ST_LOST) |->
        (r_rsp.lost_addr == '0 && r_rsp.lost_size == '0))
        else $error("lost segment reported without status");
endmodule
